/* hdl/lpd_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
// No dependencies; imported by length_prefixed_deframer_unit.
package lpd_pkg;

  localparam int unsigned LenW        = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned HdrCntW     = 2;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam logic [LenW-1:0] MaxFrameLenRst = 32'd65536;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERSIZE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // register index 0: max_frame_len
  localparam logic REG_MAX_FRAME_LEN = 1'b0;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_last;
    status_t          status;
  } result_t;

endpackage

/* hdl/length_prefixed_deframer_unit.sv */
// Length-prefixed deframer: 4-byte big-endian length header, then payload bytes.
// Depends on lpd_pkg.
//
// Usage:
//   in_*  : raw byte stream, one byte per item (in_tdata[7:0] = data_byte).
//   out_* : one item per payload byte; out_tdata[7:0] = payload byte,
//           out_tlast marks the final byte of a frame, out_tuser[1:0] = status
//           (ok, oversize, malformed). Header bytes produce no item unless the length is rejected.
//   cfg_* : APB register port; max_frame_len at byte address 0.
// A declared length above max_frame_len or equal to zero latches an error;
// from then on every byte is answered with that status and a zero payload
// until reset.
// Throughput: one byte per cycle while in_tready is high, set by the
// header/payload counter update and the 32-bit length compare done in
// the accepting cycle. Each result is registered in the output stage.
// A two-entry output stage (result register plus skid register) lets the
// block take a byte while a result waits; in_tready drops only once both
// entries are full.
// Reset (rst_n low, synchronous) returns to header phase, clears any error,
// empties the output stage and sets max_frame_len to 65536.
module length_prefixed_deframer_unit
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ByteW-1:0]    in_tdata,    // [7:0] data_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ByteW-1:0]    out_tdata,   // [7:0] payload_byte
  output logic                out_tlast,   // frame_last
  output logic [1:0]          out_tuser,   // [1:0] status
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  phase_t              phase_r, phase_nxt;
  logic [HdrCntW-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [LenW-1:0]     len_acc_r, len_acc_nxt;
  logic [LenW-1:0]     left_r, left_nxt;
  status_t             err_r, err_nxt;
  logic [LenW-1:0]     max_len_r;

  logic                in_fire;
  logic                res_vld;
  result_t             res;
  logic [LenW-1:0]     len_shift;

  logic                out_valid_r;
  result_t             out_data_r;
  logic                skid_valid_r;
  result_t             skid_data_r;
  logic                out_free;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_FRAME_LEN) ? max_len_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxFrameLenRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_MAX_FRAME_LEN) begin
      max_len_r <= cfg_pwdata;
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign len_shift = {len_acc_r[LenW-ByteW-1:0], in_tdata};

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_acc_nxt = len_acc_r;
    left_nxt    = left_r;
    err_nxt     = err_r;
    unique case (phase_r)
      PH_HEADER: begin
        len_acc_nxt = len_shift;
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        if (hdr_cnt_r == '1) begin
          if (len_shift > max_len_r) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_OVERSIZE;
          end else if (len_shift == '0) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_MALFORMED;
          end else begin
            left_nxt    = len_shift;
            len_acc_nxt = '0;
            phase_nxt   = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (left_r <= LenW'(1)) begin
          left_nxt    = '0;
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = '0;
          len_acc_nxt = '0;
        end else begin
          left_nxt = left_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // result for the current byte
  always_comb begin
    res_vld          = 1'b0;
    res.payload_byte = '0;
    res.frame_last   = 1'b0;
    res.status       = err_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_cnt_r == '1 && (len_shift > max_len_r || len_shift == '0)) begin
          res_vld    = 1'b1;
          res.status = (len_shift > max_len_r) ? ST_OVERSIZE : ST_MALFORMED;
        end
      end
      PH_PAYLOAD: begin
        res_vld          = 1'b1;
        res.payload_byte = in_tdata;
        res.frame_last   = (left_r <= LenW'(1));
        res.status       = ST_OK;
      end
      default: begin
        res_vld = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      len_acc_r <= '0;
      left_r    <= '0;
      err_r     <= ST_OK;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      len_acc_r <= len_acc_nxt;
      left_r    <= left_nxt;
      err_r     <= err_nxt;
    end
  end

  // output register with skid entry
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire && res_vld;
        end
      end else if (in_fire && res_vld) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire && res_vld) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r.payload_byte;
  assign out_tlast  = out_data_r.frame_last;
  assign out_tuser  = out_data_r.status;

  // error phase is terminal
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("left error phase");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0 && !out_tlast)
    else $error("error item carries data");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HEADER |-> hdr_cnt_r == '0)
    else $error("header count outside header phase");

endmodule
